[sv/ilt_pkg.sv]
// shared types, codes and defaults for the indexed list table
package ilt_pkg;

	localparam int ILT_CAPACITY    = 64;
	localparam int ILT_VALUE_WIDTH = 32;

	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int VAL_W   = 32;
	localparam int HASH_W  = 64;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
	localparam logic [OP_W-1:0] OP_GET      = 3'd3;
	localparam logic [OP_W-1:0] OP_SET      = 3'd4;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  entry_value;
		logic [HASH_W-1:0] key_hash;
	} req_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		logic               found;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] entry_count;
	} rsp_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT,
		S_DRAIN,
		S_PLACE,
		S_READ,
		S_CAPTURE,
		S_SEARCH,
		S_CHECK,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		AS_TOP,
		AS_NEXT,
		AS_ZERO,
		AS_POS
	} addr_sel_t;

	typedef struct packed {
		logic              latch;
		logic              rd;
		logic              shift;
		logic              wr_new;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              cap;
		logic              cmp;
		logic              set_code;
		logic [STAT_W-1:0] code;
		logic              addr_load;
		addr_sel_t         addr_sel;
		logic              addr_step;
		logic              rsp_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            pos_lt_cnt;
		logic            pos_last;
		logic            walk_last;
		logic            rsp_free;
	} dp_stat_t;

endpackage

[sv/indexed_list_table_top.sv]
// top level of the indexed list table: controller, datapath and entry memory
// steps after decode: set, errors, full, unused codes and the last-entry remove just finish;
// append and insert at the end place; get reads, then captures; contains searches, then checks
// when not empty; insert below the count shifts, drains and places; other removes shift, drain
// one at a time: next transfer the cycle after the result loads, even while that result waits
// arst_n clears the entry count, the controller and the result valid; memory is not cleared
module indexed_list_table_top import ilt_pkg::*; #(
	parameter int CAPACITY    = ILT_CAPACITY,
	parameter int VALUE_WIDTH = ILT_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	// command and status between the state machine and the datapath
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// controller: decodes the operation, sequences shifts, reads and searches
	ilt_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	// datapath: holds the request, the count, the entry memory and the result register
	ilt_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

[sv/ilt_ram.sv]
// generic simple dual port ram, one write and one registered read
module ilt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/ilt_ctl.sv]
// controller state machine for the indexed list table
module ilt_ctl import ilt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     req_stall
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (stat.op) inside
					OP_APPEND, OP_INSERT: begin
						if (stat.full) state_d = S_FINISH;
						else if (stat.op == OP_APPEND || !stat.pos_lt_cnt) state_d = S_PLACE;
						else state_d = S_SHIFT;
					end
					OP_REMOVE: begin
						if (!stat.pos_lt_cnt || stat.pos_last) state_d = S_FINISH;
						else state_d = S_SHIFT;
					end
					OP_GET: begin
						state_d = stat.pos_lt_cnt ? S_READ : S_FINISH;
					end
					OP_CONTAINS: begin
						state_d = stat.empty ? S_FINISH : S_SEARCH;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_SHIFT: begin
				if (stat.walk_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = (stat.op == OP_INSERT) ? S_PLACE : S_FINISH;
			end
			S_PLACE:   state_d = S_FINISH;
			S_READ:    state_d = S_CAPTURE;
			S_CAPTURE: state_d = S_FINISH;
			S_SEARCH: begin
				if (stat.walk_last) state_d = S_CHECK;
			end
			S_CHECK:   state_d = S_FINISH;
			S_FINISH: begin
				if (stat.rsp_free) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr_sel = AS_ZERO;
		cmd.code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = req_valid;
			end
			S_DECODE: begin
				unique case (stat.op) inside
					OP_APPEND, OP_INSERT: begin
						if (stat.full) begin
							cmd.set_code = 1'b1;
							cmd.code = ST_FULL;
						end else if (stat.op == OP_INSERT && stat.pos_lt_cnt) begin
							cmd.addr_load = 1'b1;
							cmd.addr_sel = AS_TOP;
						end
					end
					OP_REMOVE: begin
						if (!stat.pos_lt_cnt) begin
							cmd.set_code = 1'b1;
							cmd.code = ST_BOUNDS;
						end else if (stat.pos_last) begin
							cmd.cnt_dec = 1'b1;
						end else begin
							cmd.addr_load = 1'b1;
							cmd.addr_sel = AS_NEXT;
						end
					end
					OP_GET: begin
						if (!stat.pos_lt_cnt) begin
							cmd.set_code = 1'b1;
							cmd.code = ST_BOUNDS;
						end else begin
							cmd.addr_load = 1'b1;
							cmd.addr_sel = AS_POS;
						end
					end
					OP_SET: begin
						if (!stat.pos_lt_cnt) begin
							cmd.set_code = 1'b1;
							cmd.code = ST_BOUNDS;
						end else begin
							cmd.wr_new = 1'b1;
						end
					end
					OP_CONTAINS: begin
						if (!stat.empty) begin
							cmd.addr_load = 1'b1;
							cmd.addr_sel = AS_ZERO;
						end
					end
					default: ;
				endcase
			end
			S_SHIFT: begin
				cmd.rd = 1'b1;
				cmd.shift = 1'b1;
				cmd.addr_step = 1'b1;
			end
			S_DRAIN: begin
				cmd.shift = 1'b1;
				cmd.cnt_dec = (stat.op != OP_INSERT);
			end
			S_PLACE: begin
				cmd.wr_new = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_READ: begin
				cmd.rd = 1'b1;
			end
			S_CAPTURE: begin
				cmd.cap = 1'b1;
			end
			S_SEARCH: begin
				cmd.rd = 1'b1;
				cmd.cmp = 1'b1;
				cmd.addr_step = 1'b1;
			end
			S_CHECK: begin
				cmd.cmp = 1'b1;
			end
			S_FINISH: begin
				cmd.rsp_load = stat.rsp_free;
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

[sv/ilt_dp.sv]
// datapath: entry memory, count, walk address and result register
module ilt_dp import ilt_pkg::*; #(
	parameter int CAPACITY    = ILT_CAPACITY,
	parameter int VALUE_WIDTH = ILT_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output rsp_item_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_stall
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
	localparam int DW = HASH_W + SW;
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	req_item_t         item_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     rd_addr_s1;
	logic              rd_live_s1;
	logic [STAT_W-1:0] status_q;
	logic              found_q;
	logic [SW-1:0]     value_q;
	rsp_item_t         rsp_q;
	logic              rsp_valid_q;

	logic [XW-1:0] pos_x, cnt_x;
	logic          pos_lt_cnt, ins_end, is_insert, hit, rsp_free;
	logic [AW-1:0] new_addr, end_addr, load_addr;
	logic          we;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data, rd_data;

	assign pos_x      = XW'(item_q.position);
	assign cnt_x      = XW'(count_q);
	assign pos_lt_cnt = pos_x < cnt_x;
	assign is_insert  = (item_q.operation == OP_INSERT);
	assign ins_end    = (item_q.operation == OP_APPEND) || !pos_lt_cnt;
	assign new_addr   = ins_end ? AW'(count_q) : AW'(item_q.position);
	assign end_addr   = is_insert ? AW'(item_q.position) : AW'(count_q - CW'(1));
	assign hit        = (rd_data[DW-1:SW] == item_q.key_hash);
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		case (cmd.addr_sel)
			AS_TOP:  load_addr = AW'(count_q - CW'(1));
			AS_NEXT: load_addr = AW'(pos_x + XW'(1));
			AS_POS:  load_addr = AW'(item_q.position);
			default: load_addr = '0;
		endcase
	end

	// new entry wins the write port; otherwise write back the word read last cycle
	assign we      = cmd.wr_new || (cmd.shift && rd_live_s1);
	assign wr_addr = cmd.wr_new ? new_addr :
		(is_insert ? rd_addr_s1 + AW'(1) : rd_addr_s1 - AW'(1));
	assign wr_data = cmd.wr_new ? {item_q.key_hash, SW'(item_q.entry_value)} : rd_data;

	ilt_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_live_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_live_s1 <= cmd.rd;
			if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec) count_q <= count_q - CW'(1);
			if (cmd.rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q   <= req;
			status_q <= ST_OK;
			found_q  <= 1'b0;
			value_q  <= '0;
		end
		if (cmd.set_code) status_q <= cmd.code;
		if (cmd.cap) value_q <= rd_data[SW-1:0];
		if (cmd.cmp && rd_live_s1 && hit) found_q <= 1'b1;
		if (cmd.addr_load) addr_q <= load_addr;
		else if (cmd.addr_step) addr_q <= is_insert ? addr_q - AW'(1) : addr_q + AW'(1);
		if (cmd.rd) rd_addr_s1 <= addr_q;
		if (cmd.rsp_load) begin
			rsp_q.read_value  <= VAL_W'(value_q);
			rsp_q.found       <= found_q;
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= COUNT_W'(count_q);
		end
	end

	assign stat.op         = item_q.operation;
	assign stat.full       = (count_q == CW'(CAPACITY));
	assign stat.empty      = (count_q == '0);
	assign stat.pos_lt_cnt = pos_lt_cnt;
	assign stat.pos_last   = ((pos_x + XW'(1)) == cnt_x);
	assign stat.walk_last  = (addr_q == end_addr);
	assign stat.rsp_free   = rsp_free;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

[tb/sv/ilt_table_checker.sv]
// checker for the indexed list table: shadow table, expected results and field compare
module ilt_table_checker import ilt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_item_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_item_t rsp,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [VAL_W-1:0]  shadow_value [ILT_CAPACITY];
	logic [HASH_W-1:0] shadow_hash  [ILT_CAPACITY];
	int                shadow_count;
	int                mismatches;
	rsp_item_t         expected_rsp_q [$];
	rsp_item_t         want_rsp;

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// applies one operation to the shadow table and returns the result it should give
	function automatic rsp_item_t table_apply(req_item_t item);
		rsp_item_t res;
		int        slot;
		res        = '0;
		res.status = ST_OK;
		slot       = int'(item.position);
		case (item.operation)
			OP_APPEND, OP_INSERT: begin
				if (shadow_count >= ILT_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					if (item.operation == OP_APPEND || slot > shadow_count)
						slot = shadow_count;
					for (int i = shadow_count; i > slot; i--) begin
						shadow_value[i] = shadow_value[i-1];
						shadow_hash[i]  = shadow_hash[i-1];
					end
					shadow_value[slot] = item.entry_value;
					shadow_hash[slot]  = item.key_hash;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (slot >= shadow_count) begin
					res.status = ST_BOUNDS;
				end else begin
					for (int i = slot; i + 1 < shadow_count; i++) begin
						shadow_value[i] = shadow_value[i+1];
						shadow_hash[i]  = shadow_hash[i+1];
					end
					shadow_count--;
				end
			end
			OP_GET: begin
				if (slot >= shadow_count)
					res.status = ST_BOUNDS;
				else
					res.read_value = shadow_value[slot];
			end
			OP_SET: begin
				if (slot >= shadow_count) begin
					res.status = ST_BOUNDS;
				end else begin
					shadow_value[slot] = item.entry_value;
					shadow_hash[slot]  = item.key_hash;
				end
			end
			OP_CONTAINS: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_hash[i] == item.key_hash)
						res.found = 1'b1;
				end
			end
			default: ;
		endcase
		res.entry_count = COUNT_W'(shadow_count);
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("result with nothing outstanding", '0, 64'(rsp));
				end else begin
					want_rsp = expected_rsp_q.pop_front();
					if (rsp.read_value !== want_rsp.read_value)
						report_mismatch("read_value", 64'(want_rsp.read_value),
							64'(rsp.read_value));
					if (rsp.found !== want_rsp.found)
						report_mismatch("found", 64'(want_rsp.found), 64'(rsp.found));
					if (rsp.status !== want_rsp.status)
						report_mismatch("status", 64'(want_rsp.status), 64'(rsp.status));
					if (rsp.entry_count !== want_rsp.entry_count)
						report_mismatch("entry_count", 64'(want_rsp.entry_count),
							64'(rsp.entry_count));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(table_apply(req));
		end
		pending    <= expected_rsp_q.size();
		fail_count <= mismatches;
	end

endmodule

[tb/sv/tb_indexed_list_table_top.sv]
// testbench top for the indexed list table: stimulus, handshake pacing and verdict
module tb_indexed_list_table_top import ilt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// run length and safety limits
	localparam int LIMIT_CYCLES = 400_000;
	localparam int RANDOM_ITEMS = 750;
	localparam int TAIL_CYCLES  = 100;

	// operation codes the block treats as no-ops
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	// receiver stall patterns
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_mode_t;

	// flavors of random stimulus segments
	typedef enum logic [1:0] {
		SEG_GROW,
		SEG_SHRINK,
		SEG_MIXED,
		SEG_NOISE
	} seg_kind_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_item_t   req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp;
	int          fail_count;
	int          pending;

	int          cycle_count = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	int          stall_left  = 0;

	// stimulus-side state: entry count as seen by the sender, burst pacing, hash pool
	int          fill       = 0;
	int          burst_left = 0;
	logic [HASH_W-1:0] hash_pool [8];

	indexed_list_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	ilt_table_checker table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung block or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure: switches between randomly chosen patterns
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
			stall_left <= $urandom_range(16, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:   rsp_stall <= 1'b0;
			STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			default:      rsp_stall <= ((cycle_count % 7) < 3);
		endcase
	end

	function automatic req_item_t make_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val, logic [HASH_W-1:0] hash);
		req_item_t item;
		item.operation   = op;
		item.position    = pos;
		item.entry_value = val;
		item.key_hash    = hash;
		return item;
	endfunction

	// random operation shaped by segment flavor; positions mostly land inside the table
	function automatic req_item_t pick_item(seg_kind_t seg);
		req_item_t item;
		int        roll;
		int        span;
		int        vroll;
		roll = $urandom_range(0, 99);
		case (seg)
			SEG_GROW:
				item.operation = (roll < 55) ? OP_APPEND : (roll < 80) ? OP_INSERT :
					(roll < 88) ? OP_GET : (roll < 94) ? OP_SET : OP_CONTAINS;
			SEG_SHRINK:
				item.operation = (roll < 50) ? OP_REMOVE : (roll < 60) ? OP_INSERT :
					(roll < 75) ? OP_GET : (roll < 88) ? OP_SET : OP_CONTAINS;
			SEG_MIXED:
				item.operation = OP_W'($urandom_range(OP_APPEND, OP_CONTAINS));
			default:
				item.operation = OP_W'($urandom_range(OP_APPEND, OP_UNUSED_HI));
		endcase
		// insert may point one past the last entry, the others stop at the last one
		span = (item.operation == OP_INSERT) ? fill : fill - 1;
		if (span > ILT_CAPACITY - 1)
			span = ILT_CAPACITY - 1;
		if (seg != SEG_NOISE && span >= 0 && $urandom_range(0, 9) != 0)
			item.position = POS_W'($urandom_range(0, span));
		else
			item.position = POS_W'($urandom);
		vroll = $urandom_range(0, 7);
		item.entry_value = (vroll == 0) ? '0 : (vroll == 1) ? '1 : VAL_W'($urandom);
		// pool hashes repeat so contains gets hits
		if ($urandom_range(0, 1) == 0)
			item.key_hash = hash_pool[$urandom_range(0, 7)];
		else
			item.key_hash = {$urandom, $urandom};
		return item;
	endfunction

	// one transfer on the request channel; valid stays high between items of a burst
	task automatic send_item(req_item_t item);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// now and then a long stretch with no idling
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) :
				$urandom_range(1, 16);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		burst_left--;
		// sender-side entry count, only used to aim positions
		case (item.operation)
			OP_APPEND, OP_INSERT: if (fill < ILT_CAPACITY) fill++;
			OP_REMOVE:            if (int'(item.position) < fill) fill--;
			default: ;
		endcase
	endtask

	// drop valid and hold off until every outstanding result has come back
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		seg_kind_t seg;
		int        seg_left;
		int        counted;
		req_item_t item;

		hash_pool[0] = '0;
		hash_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			hash_pool[i] = {$urandom, $urandom};

		// reset held, then released on a rising edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-table bounds errors and a search with nothing stored
		send_item(make_item(OP_GET,      6'd0,  32'h0, 64'h0));
		send_item(make_item(OP_REMOVE,   6'd63, 32'h0, 64'h0));
		send_item(make_item(OP_SET,      6'd0,  '1,    '1));
		send_item(make_item(OP_CONTAINS, 6'd0,  32'h0, 64'h0));
		// insert past the end on an empty table lands at the end
		send_item(make_item(OP_INSERT,   6'd63, 32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF));
		// extremes of value and hash
		send_item(make_item(OP_APPEND,   6'd0,  32'h0, 64'h0));
		send_item(make_item(OP_APPEND,   6'd63, '1,    '1));
		// insert at the front, exactly at the count, and in the middle
		send_item(make_item(OP_INSERT,   6'd0,  32'h1111_2222, 64'hFEDC_BA98_7654_3210));
		send_item(make_item(OP_INSERT,   6'd4,  32'h3333_4444, 64'h5555_AAAA_5555_AAAA));
		send_item(make_item(OP_INSERT,   6'd2,  32'h8000_0001, 64'h8000_0000_0000_0001));
		// reads at both ends and past the end
		send_item(make_item(OP_GET,      6'd0,  32'h0, 64'h0));
		send_item(make_item(OP_GET,      6'd5,  32'h0, 64'h0));
		send_item(make_item(OP_GET,      6'd6,  32'h0, 64'h0));
		send_item(make_item(OP_GET,      6'd63, '1,    '1));
		// overwrite the first entry, then an out-of-bounds overwrite
		send_item(make_item(OP_SET,      6'd0,  '1,    '1));
		send_item(make_item(OP_SET,      6'd63, 32'h0, 64'h0));
		// searches: hits on both extreme hashes and a miss
		send_item(make_item(OP_CONTAINS, 6'd0,  32'h0, '1));
		send_item(make_item(OP_CONTAINS, 6'd63, '1,    64'h0));
		send_item(make_item(OP_CONTAINS, 6'd0,  32'h0, 64'hDEAD_BEEF_0BAD_F00D));
		// removes at the front, at the last entry, and past the end
		send_item(make_item(OP_REMOVE,   6'd0,  32'h0, 64'h0));
		send_item(make_item(OP_REMOVE,   6'd4,  32'h0, 64'h0));
		send_item(make_item(OP_REMOVE,   6'd63, 32'h0, 64'h0));
		// unused operation codes are no-ops
		send_item(make_item(OP_UNUSED_LO, 6'd63, '1, '1));
		send_item(make_item(OP_UNUSED_HI, 6'd0,  '1, '1));
		send_item(make_item(OP_GET,      6'd1,  32'h0, 64'h0));

		// sender holds off until the directed results are all back
		wait_results_drained();

		// random: the first segment grows the table until it is full and pushes past it
		counted  = 0;
		seg      = SEG_GROW;
		seg_left = 90;
		while (counted < RANDOM_ITEMS) begin
			item = pick_item(seg);
			send_item(item);
			if (item.operation <= OP_CONTAINS)
				counted++;
			seg_left--;
			if (seg_left == 0) begin
				if ($urandom_range(0, 2) == 0)
					wait_results_drained();
				seg      = seg_kind_t'($urandom_range(SEG_GROW, SEG_NOISE));
				seg_left = $urandom_range(20, 80);
			end
		end

		// drain, then idle through the tail for stray results
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
